FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: src/lvds_pkg.sv
// types, constants, microcode and helpers of the vehicle dynamics step unit
package lvds_pkg;

  // register reset values
  localparam logic [23:0] TIME_STEP_RST   = 24'd167772;
  localparam logic [31:0] MASS_RECIP_RST  = 32'd2863311;
  localparam logic [23:0] RADIUS_RECIP_RST = 24'd218453;
  localparam logic [31:0] GRADE_FORCE_RST = 32'd56499;
  localparam logic [23:0] DRAG_FACTOR_RST = 24'd6643777;

  // 30/pi in Q4.24
  localparam logic [27:0] RPM_K = 28'd160210611;

  // sequencer geometry
  localparam int          STEP_W    = 5;
  localparam logic [4:0]  LAST_STEP = 5'd16;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TIME_STEP    = 3'd0,
    REG_MASS_RECIP   = 3'd1,
    REG_RADIUS_RECIP = 3'd2,
    REG_GRADE_FORCE  = 3'd3,
    REG_DRAG_FACTOR  = 3'd4
  } cfg_reg_t;

  // multiplier operand a
  typedef enum logic [3:0] {
    MA_ZERO = 4'd0,
    MA_SPD  = 4'd1,
    MA_TRQ  = 4'd2,
    MA_VM   = 4'd3,
    MA_DF   = 4'd4,
    MA_NLO  = 4'd5,
    MA_NHI  = 4'd6,
    MA_ACC  = 4'd7,
    MA_OLO  = 4'd8,
    MA_OHI  = 4'd9
  } mul_a_t;

  // multiplier operand b
  typedef enum logic [2:0] {
    MB_ZERO = 3'd0,
    MB_TS   = 3'd1,
    MB_RR   = 3'd2,
    MB_VM   = 3'd3,
    MB_SQHI = 3'd4,
    MB_SQLO = 3'd5,
    MB_MR   = 3'd6,
    MB_K    = 3'd7
  } mul_b_t;

  // writeback operation on the previous product
  typedef enum logic [3:0] {
    WB_NONE    = 4'd0,
    WB_TRQ     = 4'd1,
    WB_DIST    = 4'd2,
    WB_SQ      = 4'd3,
    WB_FW      = 4'd4,
    WB_FD      = 4'd5,
    WB_FD_ADD  = 4'd6,
    WB_NET     = 4'd7,
    WB_LO      = 4'd8,
    WB_ACC     = 4'd9,
    WB_SPD     = 4'd10,
    WB_OM      = 4'd11,
    WB_OUT     = 4'd12
  } wb_t;

  // jump conditions
  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_NO_ITEM  = 2'd1,
    COND_OUT_BUSY = 2'd2
  } cond_t;

  // one control word
  typedef struct packed {
    logic       mul_en;
    mul_a_t     a;
    mul_b_t     b;
    wb_t        wb;
    cond_t      cond;
    logic [4:0] target;
    logic       last;
  } ucode_t;

  function automatic ucode_t uw(input logic mul_en, input mul_a_t a, input mul_b_t b,
                                input wb_t wb, input cond_t cond, input logic [4:0] target,
                                input logic last);
    ucode_t w;
    w.mul_en = mul_en;
    w.a      = a;
    w.b      = b;
    w.wb     = wb;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // microcode rom: each step issues at most one multiply and may retire the previous product
  function automatic ucode_t ucode(input logic [4:0] pc);
    ucode_t w;
    unique case (pc)
      5'd0:  w = uw(1'b1, MA_SPD,  MB_TS,   WB_TRQ,    COND_NO_ITEM,  5'd0,  1'b0);
      5'd1:  w = uw(1'b1, MA_VM,   MB_VM,   WB_DIST,   COND_NEVER,    5'd0,  1'b0);
      5'd2:  w = uw(1'b1, MA_TRQ,  MB_RR,   WB_SQ,     COND_NEVER,    5'd0,  1'b0);
      5'd3:  w = uw(1'b1, MA_DF,   MB_SQHI, WB_FW,     COND_NEVER,    5'd0,  1'b0);
      5'd4:  w = uw(1'b1, MA_DF,   MB_SQLO, WB_FD,     COND_NEVER,    5'd0,  1'b0);
      5'd5:  w = uw(1'b0, MA_ZERO, MB_ZERO, WB_FD_ADD, COND_NEVER,    5'd0,  1'b0);
      5'd6:  w = uw(1'b0, MA_ZERO, MB_ZERO, WB_NET,    COND_NEVER,    5'd0,  1'b0);
      5'd7:  w = uw(1'b1, MA_NLO,  MB_MR,   WB_NONE,   COND_NEVER,    5'd0,  1'b0);
      5'd8:  w = uw(1'b1, MA_NHI,  MB_MR,   WB_LO,     COND_NEVER,    5'd0,  1'b0);
      5'd9:  w = uw(1'b0, MA_ZERO, MB_ZERO, WB_ACC,    COND_NEVER,    5'd0,  1'b0);
      5'd10: w = uw(1'b1, MA_ACC,  MB_TS,   WB_NONE,   COND_NEVER,    5'd0,  1'b0);
      5'd11: w = uw(1'b0, MA_ZERO, MB_ZERO, WB_SPD,    COND_NEVER,    5'd0,  1'b0);
      5'd12: w = uw(1'b1, MA_SPD,  MB_RR,   WB_NONE,   COND_NEVER,    5'd0,  1'b0);
      5'd13: w = uw(1'b0, MA_ZERO, MB_ZERO, WB_OM,     COND_NEVER,    5'd0,  1'b0);
      5'd14: w = uw(1'b1, MA_OLO,  MB_K,    WB_NONE,   COND_NEVER,    5'd0,  1'b0);
      5'd15: w = uw(1'b1, MA_OHI,  MB_K,    WB_LO,     COND_NEVER,    5'd0,  1'b0);
      5'd16: w = uw(1'b0, MA_ZERO, MB_ZERO, WB_OUT,    COND_OUT_BUSY, 5'd16, 1'b1);
      default: w = uw(1'b0, MA_ZERO, MB_ZERO, WB_NONE, COND_NEVER,    5'd0,  1'b1);
    endcase
    return w;
  endfunction

  // saturate to 48, 32 and 24 bit signed ranges
  function automatic logic [47:0] sat48(input logic signed [63:0] x);
    logic [47:0] r;
    if (&x[63:47] || ~|x[63:47]) r = x[47:0];
    else r = x[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (&x[63:31] || ~|x[63:31]) r = x[31:0];
    else r = x[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    return r;
  endfunction

  function automatic logic [23:0] sat24(input logic signed [63:0] x);
    logic [23:0] r;
    if (&x[63:23] || ~|x[63:23]) r = x[23:0];
    else r = x[63] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}};
    return r;
  endfunction

endpackage

FILE: src/longitudinal_vehicle_dynamics_step_unit.sv
// top level: microcoded euler step of longitudinal vehicle dynamics
// One item (a wheel torque) advances the vehicle by one explicit Euler tick: distance grows by
// the old speed times the time step, acceleration follows from wheel force, grade force and
// quadratic drag over mass, speed grows by acceleration times the time step, and wheel rpm is
// taken from the new speed. All math runs on a single shared 33x33 signed multiplier driven by
// a 17-step microcode program, which takes a new item only at step 0, so items wait while it runs;
// a held result stalls the program at its last step until the output register frees.
// Configuration writes take effect at once and are meant to be made while the unit is idle.
`include "assert_macros.svh"

module longitudinal_vehicle_dynamics_step_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [23:0] drive_torque,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [23:0] wheel_speed_rpm,
  output logic signed [31:0] vehicle_speed,
  output logic signed [47:0] distance,
  output logic signed [31:0] acceleration
);

  // configuration registers
  logic [23:0]        time_step;
  logic [31:0]        mass_reciprocal;
  logic [23:0]        radius_reciprocal;
  logic signed [31:0] grade_force;
  logic [23:0]        drag_factor;

  // vehicle state
  logic signed [31:0] speed_reg;
  logic signed [47:0] distance_reg;

  // sequencer
  logic [lvds_pkg::STEP_W-1:0] pc;
  logic [lvds_pkg::STEP_W-1:0] pc_next;
  lvds_pkg::ucode_t            uc;
  logic                        jump;
  logic                        out_busy;

  // datapath registers
  logic signed [63:0] prod;
  logic signed [23:0] trq;
  logic [46:0]        sq;
  logic signed [40:0] fw;
  logic [47:0]        fd;
  logic signed [49:0] net;
  logic [31:0]        lo;
  logic signed [31:0] acc;
  logic signed [40:0] om;

  // combinational datapath
  logic signed [32:0] vm;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] dist_sum;
  logic signed [63:0] spd_sum;
  logic signed [63:0] part_sum;
  logic signed [49:0] net_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step         <= lvds_pkg::TIME_STEP_RST;
      mass_reciprocal   <= lvds_pkg::MASS_RECIP_RST;
      radius_reciprocal <= lvds_pkg::RADIUS_RECIP_RST;
      grade_force       <= lvds_pkg::GRADE_FORCE_RST;
      drag_factor       <= lvds_pkg::DRAG_FACTOR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lvds_pkg::REG_TIME_STEP:    time_step         <= cfg_data[23:0];
        lvds_pkg::REG_MASS_RECIP:   mass_reciprocal   <= cfg_data;
        lvds_pkg::REG_RADIUS_RECIP: radius_reciprocal <= cfg_data[23:0];
        lvds_pkg::REG_GRADE_FORCE:  grade_force       <= cfg_data;
        lvds_pkg::REG_DRAG_FACTOR:  drag_factor       <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // control word and jump decision
  assign uc         = lvds_pkg::ucode(pc);
  assign out_busy   = result_valid && result_stall;
  assign item_stall = (pc != '0);

  always_comb begin
    unique case (uc.cond)
      lvds_pkg::COND_NO_ITEM:  jump = !item_valid;
      lvds_pkg::COND_OUT_BUSY: jump = out_busy;
      default:                 jump = 1'b0;
    endcase
    if (jump) pc_next = uc.target;
    else if (uc.last) pc_next = '0;
    else pc_next = pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  // operand selection for the shared multiplier
  assign vm = speed_reg[31] ? -{speed_reg[31], speed_reg} : {speed_reg[31], speed_reg};

  always_comb begin
    case (uc.a)
      lvds_pkg::MA_SPD: mul_a = {speed_reg[31], speed_reg};
      lvds_pkg::MA_TRQ: mul_a = {{9{trq[23]}}, trq};
      lvds_pkg::MA_VM:  mul_a = vm;
      lvds_pkg::MA_DF:  mul_a = {9'b0, drag_factor};
      lvds_pkg::MA_NLO: mul_a = {9'b0, net[23:0]};
      lvds_pkg::MA_NHI: mul_a = {{7{net[49]}}, net[49:24]};
      lvds_pkg::MA_ACC: mul_a = {acc[31], acc};
      lvds_pkg::MA_OLO: mul_a = {9'b0, om[23:0]};
      lvds_pkg::MA_OHI: mul_a = {{16{om[40]}}, om[40:24]};
      default:          mul_a = '0;
    endcase
    case (uc.b)
      lvds_pkg::MB_TS:   mul_b = {9'b0, time_step};
      lvds_pkg::MB_RR:   mul_b = {9'b0, radius_reciprocal};
      lvds_pkg::MB_VM:   mul_b = vm;
      lvds_pkg::MB_SQHI: mul_b = {10'b0, sq[46:24]};
      lvds_pkg::MB_SQLO: mul_b = {9'b0, sq[23:0]};
      lvds_pkg::MB_MR:   mul_b = {1'b0, mass_reciprocal};
      lvds_pkg::MB_K:    mul_b = {5'b0, lvds_pkg::RPM_K};
      default:           mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // product register
  always_ff @(posedge clk) begin
    if (uc.mul_en) begin
      prod <= mul_p[63:0];
    end
  end

  // writeback arithmetic on the previous product
  assign dist_sum = $signed({{16{distance_reg[47]}}, distance_reg}) + (prod >>> 24);
  assign spd_sum  = $signed({{32{speed_reg[31]}}, speed_reg}) + (prod >>> 24);
  assign part_sum = prod + $signed({32'b0, lo});
  assign net_next = $signed({{9{fw[40]}}, fw})
                  - $signed({{10{grade_force[31]}}, grade_force, 8'b0})
                  - $signed({2'b0, fd});

  // vehicle state, reset to standstill at the origin
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_reg    <= '0;
      distance_reg <= '0;
    end else begin
      if (uc.wb == lvds_pkg::WB_DIST) distance_reg <= lvds_pkg::sat48(dist_sum);
      if (uc.wb == lvds_pkg::WB_SPD) speed_reg <= lvds_pkg::sat32(spd_sum);
    end
  end

  // intermediate results
  always_ff @(posedge clk) begin
    case (uc.wb)
      lvds_pkg::WB_TRQ:    trq <= drive_torque;
      lvds_pkg::WB_SQ:     sq  <= prod[62:16];
      lvds_pkg::WB_FW:     fw  <= prod[48:8];
      lvds_pkg::WB_FD:     fd  <= prod[47:0];
      lvds_pkg::WB_FD_ADD: fd  <= fd + {24'b0, prod[47:24]};
      lvds_pkg::WB_NET:    net <= net_next;
      lvds_pkg::WB_LO:     lo  <= prod[55:24];
      lvds_pkg::WB_ACC:    acc <= lvds_pkg::sat32(part_sum >>> 8);
      lvds_pkg::WB_OM:     om  <= prod[56:16];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (uc.wb == lvds_pkg::WB_OUT && !out_busy) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.wb == lvds_pkg::WB_OUT && !out_busy) begin
      wheel_speed_rpm <= lvds_pkg::sat24(part_sum >>> 8);
      vehicle_speed   <= speed_reg;
      distance        <= distance_reg;
      acceleration    <= acc;
    end
  end

  // checks
  `ASSERT_NEXT(a_accept_starts_program, clk, rst, item_valid && !item_stall, pc == 5'd1, "accepted item did not start the program")
  `ASSERT_IMPLIES(a_result_from_last_step, clk, rst, $rose(result_valid), $past(pc) == lvds_pkg::LAST_STEP, "result appeared outside the last step")
  `ASSERT_NEXT(a_speed_held_while_idle, clk, rst, pc == '0, $stable(speed_reg), "speed changed while waiting for an item")

endmodule
